// ===== rtl/assert_macros.svh =====
// shared assertion macros, sampled on clk and quiet during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcfp_pkg.sv =====
package rcfp_pkg;

  localparam int NUM_CHANNELS_DEF = 14;
  localparam int FRAME_BYTES_DEF  = 32;

  localparam int BIDX_W    = 6;
  localparam int ELAPSED_W = 17;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

  localparam logic [15:0] TIMEOUT_RST  = 16'd100;
  localparam logic [7:0]  HDR_FIRST_RST  = 8'd32;
  localparam logic [7:0]  HDR_SECOND_RST = 8'd64;

  // register index, paddr[3:2]
  localparam logic [1:0] REG_TIMEOUT    = 2'd0;
  localparam logic [1:0] REG_HDR_FIRST  = 2'd1;
  localparam logic [1:0] REG_HDR_SECOND = 2'd2;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_CHANNEL = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  channel_number;
    logic [15:0] channel_value;
    logic        frame_good;
    logic        checksum_bad;
    logic        link_lost;
    logic        link_ready;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_limit;
    logic [7:0]  header_first;
    logic [7:0]  header_second;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [BIDX_W-1:0] idx;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [BIDX_W-1:0] idx;
  } store_rd_t;

  typedef struct packed {
    logic      status_load;
    logic      frame_start;
    out_item_t status;
  } parse_ev_t;

  typedef struct packed {
    logic busy;
    logic pending;
    logic accept_ok;
  } emit_stat_t;

endpackage

// ===== rtl/rc_serial_frame_parser_unit.sv =====
// channel   direction  handshake                payload
// rx        in         rx_valid / rx_stall      rcfp_pkg::in_item_t  (mode, rx_byte)
// res       out        res_valid / res_stall    rcfp_pkg::out_item_t (kind .. last)
// apb       in/out     psel, penable, pready    paddr, pwdata, prdata
//
// a byte or tick item is taken and its status item sits in the result register
// right after that edge; items may arrive every cycle while rx_stall is low
// a good frame gives NUM_CHANNELS items, one per cycle while res_stall is low, each
// read from the store, then registered; rx is held off until the last one is in the result reg
// rst is synchronous: parser clear, header values and timeout back to reset
// res_stall holds the result register; rx stalls while it is full and stuck
module rc_serial_frame_parser_unit #(
  parameter int NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF,
  parameter int FRAME_BYTES  = rcfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rx_valid,
  output logic                         rx_stall,
  input  rcfp_pkg::in_item_t           rx_item,
  output logic                         res_valid,
  input  logic                         res_stall,
  output rcfp_pkg::out_item_t          res_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcfp_pkg::PADDR_W-1:0] paddr,
  input  logic [rcfp_pkg::PDATA_W-1:0] pwdata,
  output logic [rcfp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  `include "assert_macros.svh"

  rcfp_pkg::cfg_t       cfg;
  rcfp_pkg::store_wr_t  wr;
  rcfp_pkg::store_rd_t  rd;
  rcfp_pkg::parse_ev_t  ev;
  rcfp_pkg::emit_stat_t stat;
  logic [7:0]           rd_even, rd_odd;
  logic                 rx_acc;

  // accept only when no channel burst is pending and the result slot frees
  assign rx_stall = !stat.accept_ok;
  assign rx_acc   = rx_valid && !rx_stall;

  rcfp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // header sync, running sum, checksum test, elapsed timer
  rcfp_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .acc  (rx_acc),
    .item (rx_item),
    .cfg  (cfg),
    .wr   (wr),
    .ev   (ev)
  );

  // frame bytes, read back a channel word at a time
  rcfp_frame_store #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_even (rd_even),
    .rd_odd  (rd_odd)
  );

  // channel burst sequencer and result register
  rcfp_emitter #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .FRAME_BYTES  (FRAME_BYTES)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .ev        (ev),
    .rd_even   (rd_even),
    .rd_odd    (rd_odd),
    .res_stall (res_stall),
    .rd        (rd),
    .res_valid (res_valid),
    .res_item  (res_item),
    .stat      (stat)
  );

  // a good frame always starts the channel burst
  `ASSERT_NEXT(a_burst_start, ev.frame_start, stat.busy, "good frame did not start burst")

  // no new item taken while channel items are still owed
  `ASSERT_SAME(a_no_acc_burst, rx_acc, !stat.busy && !stat.pending, "item taken during burst")

  // channel items only ever report a fresh good link
  `ASSERT_SAME(a_chan_fields,
               res_valid && res_item.kind == rcfp_pkg::KIND_CHANNEL,
               res_item.frame_good && res_item.link_ready && !res_item.link_lost,
               "channel item flags wrong")

  // a status item is always the only item of its input
  `ASSERT_SAME(a_status_last,
               res_valid && res_item.kind == rcfp_pkg::KIND_STATUS,
               res_item.last && !res_item.frame_good,
               "status item not last")

endmodule

// ===== rtl/rcfp_cfg_regs.sv =====
module rcfp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcfp_pkg::PADDR_W-1:0] paddr,
  input  logic [rcfp_pkg::PDATA_W-1:0] pwdata,
  output logic [rcfp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output rcfp_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_limit <= rcfp_pkg::TIMEOUT_RST;
      cfg.header_first  <= rcfp_pkg::HDR_FIRST_RST;
      cfg.header_second <= rcfp_pkg::HDR_SECOND_RST;
    end else if (wr_en) begin
      case (reg_sel)
        rcfp_pkg::REG_TIMEOUT:    cfg.timeout_limit <= pwdata[15:0];
        rcfp_pkg::REG_HDR_FIRST:  cfg.header_first  <= pwdata[7:0];
        rcfp_pkg::REG_HDR_SECOND: cfg.header_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rcfp_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg.timeout_limit};
      rcfp_pkg::REG_HDR_FIRST:  prdata = {24'd0, cfg.header_first};
      rcfp_pkg::REG_HDR_SECOND: prdata = {24'd0, cfg.header_second};
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== rtl/rcfp_parser.sv =====
module rcfp_parser #(
  parameter int FRAME_BYTES = rcfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  acc,
  input  rcfp_pkg::in_item_t    item,
  input  rcfp_pkg::cfg_t        cfg,
  output rcfp_pkg::store_wr_t   wr,
  output rcfp_pkg::parse_ev_t   ev
);

  localparam logic [rcfp_pkg::BIDX_W-1:0] FB_IDX  = rcfp_pkg::BIDX_W'(FRAME_BYTES);
  localparam logic [rcfp_pkg::BIDX_W:0]   FB_WIDE = (rcfp_pkg::BIDX_W+1)'(FRAME_BYTES);

  logic [rcfp_pkg::BIDX_W-1:0]    byte_index, byte_index_next, idx_inc;
  logic                           in_sync, in_sync_next;
  logic [15:0]                    running_sum, running_sum_next;
  logic                           seen_frame, seen_frame_next;
  logic [rcfp_pkg::ELAPSED_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [7:0]                     prev_byte, prev_byte_next;
  logic                           frame_start, chk_bad;
  logic [7:0]                     b;

  assign b       = item.rx_byte;
  assign idx_inc = byte_index + 6'd1;

  always_comb begin
    byte_index_next  = byte_index;
    in_sync_next     = in_sync;
    running_sum_next = running_sum;
    seen_frame_next  = seen_frame;
    elapsed_ms_next  = elapsed_ms;
    prev_byte_next   = prev_byte;
    frame_start      = 1'b0;
    chk_bad          = 1'b0;
    wr.en            = 1'b0;
    wr.idx           = byte_index;
    wr.data          = b;
    if (acc) begin
      if (item.mode == rcfp_pkg::MODE_TICK) begin
        if (elapsed_ms < rcfp_pkg::ELAPSED_MAX) begin
          elapsed_ms_next = elapsed_ms + 17'd1;
        end
      end else begin
        prev_byte_next = b;
        if (!in_sync) begin
          // header hunt
          if (byte_index == '0 && b == cfg.header_first) begin
            running_sum_next = 16'(b);
            wr.en            = 1'b1;
            byte_index_next  = 6'd1;
          end else if (byte_index == 6'd1 && b == cfg.header_second) begin
            running_sum_next = running_sum + 16'(b);
            wr.en            = 1'b1;
            byte_index_next  = 6'd2;
            in_sync_next     = 1'b1;
          end else begin
            byte_index_next = '0;
          end
        end else begin
          wr.en = (byte_index < FB_IDX);
          // checksum bytes stay out of the sum
          if (({1'b0, byte_index} + 7'd2) < FB_WIDE) begin
            running_sum_next = running_sum + 16'(b);
          end
          byte_index_next = idx_inc;
          if (idx_inc >= FB_IDX) begin
            byte_index_next = '0;
            in_sync_next    = 1'b0;
            if ({b, prev_byte} == ~running_sum) begin
              elapsed_ms_next = '0;
              seen_frame_next = 1'b1;
              frame_start     = 1'b1;
            end else begin
              chk_bad = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    ev.status_load           = acc && !frame_start;
    ev.frame_start           = frame_start;
    ev.status.kind           = rcfp_pkg::KIND_STATUS;
    ev.status.channel_number = '0;
    ev.status.channel_value  = '0;
    ev.status.frame_good     = 1'b0;
    ev.status.checksum_bad   = chk_bad;
    ev.status.link_lost      = !seen_frame_next ||
                               (elapsed_ms_next > {1'b0, cfg.timeout_limit});
    ev.status.link_ready     = seen_frame_next;
    ev.status.last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      in_sync     <= 1'b0;
      running_sum <= '0;
      seen_frame  <= 1'b0;
      elapsed_ms  <= '0;
    end else begin
      byte_index  <= byte_index_next;
      in_sync     <= in_sync_next;
      running_sum <= running_sum_next;
      seen_frame  <= seen_frame_next;
      elapsed_ms  <= elapsed_ms_next;
    end
    prev_byte <= prev_byte_next;
  end

endmodule

// ===== rtl/rcfp_frame_store.sv =====
module rcfp_frame_store #(
  parameter int FRAME_BYTES = rcfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  rcfp_pkg::store_wr_t wr,
  input  rcfp_pkg::store_rd_t rd,
  output logic [7:0]          rd_even,
  output logic [7:0]          rd_odd
);

  // even and odd byte banks so one read gives a whole channel word
  localparam int DEPTH = (FRAME_BYTES + 1) / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [rcfp_pkg::BIDX_W-1:0] FB_IDX = rcfp_pkg::BIDX_W'(FRAME_BYTES);

  logic [7:0]    even_mem [DEPTH];
  logic [7:0]    odd_mem  [DEPTH];
  logic [AW-1:0] wr_addr, rd_addr;

  assign wr_addr = wr.idx[AW:1];
  assign rd_addr = (rd.idx < FB_IDX) ? rd.idx[AW:1] : '0;

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx < FB_IDX) begin
      if (wr.idx[0]) begin
        odd_mem[wr_addr] <= wr.data;
      end else begin
        even_mem[wr_addr] <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_even <= even_mem[rd_addr];
      rd_odd  <= odd_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rcfp_emitter.sv =====
module rcfp_emitter #(
  parameter int NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF,
  parameter int FRAME_BYTES  = rcfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rcfp_pkg::parse_ev_t   ev,
  input  logic [7:0]            rd_even,
  input  logic [7:0]            rd_odd,
  input  logic                  res_stall,
  output rcfp_pkg::store_rd_t   rd,
  output logic                  res_valid,
  output rcfp_pkg::out_item_t   res_item,
  output rcfp_pkg::emit_stat_t  stat
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [rcfp_pkg::BIDX_W-1:0] FB_IDX = rcfp_pkg::BIDX_W'(FRAME_BYTES);
  localparam logic [CW-1:0] CH_LAST = CW'(NUM_CHANNELS - 1);

  logic                        busy;
  logic [CW-1:0]               ch_idx;
  logic                        a_valid, a_last, a_lo_ok, a_hi_ok;
  logic [4:0]                  a_num;
  logic                        b_free, a_adv, issue;
  logic [rcfp_pkg::BIDX_W-1:0] lo_idx;

  assign b_free = !res_valid || !res_stall;
  assign a_adv  = a_valid && b_free;
  assign issue  = busy && (!a_valid || a_adv);
  assign lo_idx = rcfp_pkg::BIDX_W'({ch_idx, 1'b0}) + 6'd2;

  assign rd.en  = issue;
  assign rd.idx = lo_idx;

  assign stat.busy      = busy;
  assign stat.pending   = a_valid;
  assign stat.accept_ok = !busy && !a_valid && b_free;

  // channel sequencer and read-data stage
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      ch_idx  <= '0;
      a_valid <= 1'b0;
    end else begin
      if (ev.frame_start) begin
        busy   <= 1'b1;
        ch_idx <= '0;
      end else if (issue) begin
        if (ch_idx == CH_LAST) begin
          busy <= 1'b0;
        end else begin
          ch_idx <= ch_idx + 1'b1;
        end
      end
      if (issue) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
    end
    if (issue) begin
      a_num   <= 5'(ch_idx) + 5'd1;
      a_last  <= (ch_idx == CH_LAST);
      a_lo_ok <= (lo_idx < FB_IDX);
      a_hi_ok <= ((lo_idx + 6'd1) < FB_IDX);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (a_adv || ev.status_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (a_adv) begin
      res_item.kind           <= rcfp_pkg::KIND_CHANNEL;
      res_item.channel_number <= a_num;
      res_item.channel_value  <= {a_hi_ok ? rd_odd : 8'd0, a_lo_ok ? rd_even : 8'd0};
      res_item.frame_good     <= 1'b1;
      res_item.checksum_bad   <= 1'b0;
      res_item.link_lost      <= 1'b0;
      res_item.link_ready     <= 1'b1;
      res_item.last           <= a_last;
    end else if (ev.status_load) begin
      res_item <= ev.status;
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb;

  localparam int N_CH           = rcfp_pkg::NUM_CHANNELS_DEF;
  localparam int F_BYTES        = rcfp_pkg::FRAME_BYTES_DEF;
  localparam int QUIET_LIMIT    = 2000;   // cycles with no transfer before giving up
  localparam int HOLDOFF_CYCLES = 150;    // long result-side hold-off

  // clock, reset and every dut input start at known values
  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         rx_valid  = 1'b0;
  logic                         rx_stall;
  rcfp_pkg::in_item_t           rx_item   = '0;
  logic                         res_valid;
  logic                         res_stall = 1'b0;
  rcfp_pkg::out_item_t          res_item;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [rcfp_pkg::PADDR_W-1:0] paddr     = '0;
  logic [rcfp_pkg::PDATA_W-1:0] pwdata    = '0;
  logic [rcfp_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  // items waiting to be sent, and results the parser still owes us
  rcfp_pkg::in_item_t  rx_backlog[$];
  rcfp_pkg::out_item_t outputs_due[$];
  rcfp_pkg::out_item_t want_res;

  int send_idle_pct = 31;
  int recv_idle_pct = 64;
  int fault_count   = 0;
  int quiet_cycles  = 0;
  int holdoff_left  = 0;
  bit holdoff_req   = 1'b0;
  int queued_count  = 0;

  // shadow of the parser: register copy plus sync/frame state
  rcfp_pkg::cfg_t cfg_shadow = '{timeout_limit: rcfp_pkg::TIMEOUT_RST,
                                 header_first: rcfp_pkg::HDR_FIRST_RST,
                                 header_second: rcfp_pkg::HDR_SECOND_RST};
  logic [7:0]                     frame_buf [F_BYTES];
  logic [rcfp_pkg::BIDX_W-1:0]    fill_idx       = '0;
  logic                           synced         = 1'b0;
  logic [15:0]                    sum16          = '0;
  logic                           got_frame      = 1'b0;
  logic [rcfp_pkg::ELAPSED_W-1:0] ms_since_frame = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rc_serial_frame_parser_unit #(
    .NUM_CHANNELS(N_CH),
    .FRAME_BYTES (F_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_item  (rx_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------- prediction

  // link is down until the first good frame, or once too many ms have passed
  function automatic logic link_down();
    return !got_frame || (ms_since_frame > cfg_shadow.timeout_limit);
  endfunction

  // status-only result, link flags taken from the state after the update
  function automatic rcfp_pkg::out_item_t status_result(logic bad);
    rcfp_pkg::out_item_t r;
    r = '0;
    r.kind         = rcfp_pkg::KIND_STATUS;
    r.checksum_bad = bad;
    r.link_lost    = link_down();
    r.link_ready   = got_frame;
    r.last         = 1'b1;
    return r;
  endfunction

  // bytes past the frame's end read as zero
  function automatic logic [7:0] byte_at(int i);
    return (i < F_BYTES) ? frame_buf[i] : 8'h00;
  endfunction

  // store a byte; the sum skips the two checksum bytes
  function automatic void take_byte(logic [7:0] b);
    if (int'(fill_idx) < F_BYTES) frame_buf[fill_idx] = b;
    if (int'(fill_idx) + 2 < F_BYTES) sum16 = sum16 + 16'(b);
    fill_idx = fill_idx + 1'b1;
  endfunction

  // advance the shadow parser by one accepted item and queue its results
  function automatic void parse_rx_item(rcfp_pkg::in_item_t it);
    logic [15:0]         stored_sum;
    rcfp_pkg::out_item_t r;
    if (it.mode == rcfp_pkg::MODE_TICK) begin
      // elapsed counter sticks at its maximum
      if (ms_since_frame != rcfp_pkg::ELAPSED_MAX) ms_since_frame = ms_since_frame + 1'b1;
      outputs_due.push_back(status_result(1'b0));
    end else if (!synced) begin
      // header hunt: a wrong second byte always restarts, even if it is the first
      if (fill_idx == 0 && it.rx_byte == cfg_shadow.header_first) begin
        sum16 = '0;
        take_byte(it.rx_byte);
      end else if (fill_idx == 1 && it.rx_byte == cfg_shadow.header_second) begin
        take_byte(it.rx_byte);
        synced = 1'b1;
      end else begin
        fill_idx = '0;
      end
      outputs_due.push_back(status_result(1'b0));
    end else begin
      take_byte(it.rx_byte);
      if (int'(fill_idx) < F_BYTES) begin
        outputs_due.push_back(status_result(1'b0));
      end else begin
        // frame complete: check, then resync either way
        fill_idx   = '0;
        synced     = 1'b0;
        stored_sum = {byte_at(F_BYTES - 1), byte_at(F_BYTES - 2)};
        if (stored_sum != 16'hFFFF - sum16) begin
          outputs_due.push_back(status_result(1'b1));
        end else begin
          ms_since_frame = '0;
          got_frame      = 1'b1;
          for (int c = 0; c < N_CH; c++) begin
            r                = status_result(1'b0);
            r.kind           = rcfp_pkg::KIND_CHANNEL;
            r.channel_number = 5'(c + 1);
            r.channel_value  = {byte_at(2 * c + 3), byte_at(2 * c + 2)};
            r.frame_good     = 1'b1;
            r.last           = (c == N_CH - 1);
            outputs_due.push_back(r);
          end
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_byte(logic [7:0] b);
    rx_backlog.push_back(rcfp_pkg::in_item_t'{rcfp_pkg::MODE_BYTE, b});
    queued_count++;
  endfunction

  // tick items carry a junk byte that the parser must ignore
  function automatic void push_ticks(int n);
    repeat (n) begin
      rx_backlog.push_back(rcfp_pkg::in_item_t'{rcfp_pkg::MODE_TICK, 8'($urandom)});
      queued_count++;
    end
  endfunction

  // one whole frame for the current headers, ticks sprinkled in between bytes
  function automatic void queue_frame(bit corrupt, bit extremes);
    logic [7:0]  fb [F_BYTES];
    logic [15:0] s;
    int          pos;
    fb[0] = cfg_shadow.header_first;
    fb[1] = cfg_shadow.header_second;
    for (int i = 2; i < F_BYTES - 2; i++) fb[i] = 8'($urandom);
    if (extremes) begin
      // channel 1 all ones, channel 2 all zeros, channel 3 both end bits
      fb[2] = 8'hFF; fb[3] = 8'hFF;
      fb[4] = 8'h00; fb[5] = 8'h00;
      fb[6] = 8'h01; fb[7] = 8'h80;
    end
    s = '0;
    for (int i = 0; i < F_BYTES - 2; i++) s = s + 16'(fb[i]);
    s = 16'hFFFF - s;
    fb[F_BYTES - 2] = s[7:0];
    fb[F_BYTES - 1] = s[15:8];
    if (corrupt) begin
      // one flipped bit past the header always breaks the check
      pos     = $urandom_range(F_BYTES - 1, 2);
      fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(7));
    end
    for (int i = 0; i < F_BYTES; i++) begin
      if ($urandom_range(9) == 0) push_ticks(1);
      push_byte(fb[i]);
    end
  endfunction

  // mostly clean frames, plus tick bursts, line noise and broken headers
  function automatic void queue_traffic(int target, bit bad_first);
    int goal;
    int pick;
    goal = queued_count + target;
    while (queued_count < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        queue_frame(bad_first || $urandom_range(3) == 0, 1'b0);
        bad_first = 1'b0;
      end else if (pick < 75) begin
        push_ticks($urandom_range(8, 1));
      end else if (pick < 88) begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom));
      end else begin
        push_byte(cfg_shadow.header_first);
        push_byte($urandom_range(1) ? cfg_shadow.header_first : 8'($urandom));
      end
    end
  endfunction

  // apb write: setup cycle, then access until pready; shadow follows
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rcfp_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rcfp_pkg::REG_TIMEOUT:    cfg_shadow.timeout_limit = val[15:0];
      rcfp_pkg::REG_HDR_FIRST:  cfg_shadow.header_first  = val[7:0];
      rcfp_pkg::REG_HDR_SECOND: cfg_shadow.header_second = val[7:0];
      default: ;
    endcase
  endtask

  // settle on the falling edge so driver and monitor updates are all visible
  task automatic wait_quiet();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || rx_valid || outputs_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic string fmt_res(rcfp_pkg::out_item_t r);
    return $sformatf("kind=%0d ch=%0d val=%h good=%b bad=%b lost=%b ready=%b last=%b",
                     r.kind, r.channel_number, r.channel_value, r.frame_good,
                     r.checksum_bad, r.link_lost, r.link_ready, r.last);
  endfunction

  // ---------------------------------------------------------------- driver

  // an item leaves the backlog only when the previous one was taken
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall) parse_rx_item(rx_item);
      if (!rx_valid || !rx_stall) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_item  <= rx_backlog.pop_front();
          rx_valid <= 1'b1;
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  // checks each taken result against the oldest one owed, then picks the stall
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (outputs_due.size() == 0) begin
          fault_count++;
          $display("%0t: result with none owed: %s", $time, fmt_res(res_item));
        end else begin
          want_res = outputs_due.pop_front();
          if (res_item !== want_res) begin
            fault_count++;
            $display("%0t: result mismatch", $time);
            $display("  expected %s", fmt_res(want_res));
            $display("  actual   %s", fmt_res(res_item));
          end
        end
      end
      // long hold-off so the parser backs up into rx_stall
      if (holdoff_req) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_req  = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (!rst) begin
      if ((rx_valid && !rx_stall) || (res_valid && !res_stall) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset headers 32/64: tick before any frame, byte extremes
    push_ticks(1);
    push_byte(8'h00);
    push_byte(8'hFF);
    // second header byte equal to the first one: hunt restarts, then stray 64
    push_byte(rcfp_pkg::HDR_FIRST_RST);
    push_byte(rcfp_pkg::HDR_FIRST_RST);
    push_byte(rcfp_pkg::HDR_SECOND_RST);
    // plain wrong second byte
    push_byte(rcfp_pkg::HDR_FIRST_RST);
    push_byte(8'h11);
    // good frame with extreme channel values, then ticks within the timeout
    queue_frame(1'b0, 1'b1);
    push_ticks(2);
    wait_quiet();

    // zero timeout, extreme header values; first frame has a bad checksum
    reg_write(rcfp_pkg::REG_TIMEOUT,    {16'($urandom), 16'd0});
    reg_write(rcfp_pkg::REG_HDR_FIRST,  {24'($urandom), 8'h00});
    reg_write(rcfp_pkg::REG_HDR_SECOND, {24'($urandom), 8'hFF});
    queue_traffic(12, 1'b1);
    wait_quiet();

    // sender now the slow side
    send_idle_pct = 64;
    recv_idle_pct = 31;
    reg_write(rcfp_pkg::REG_TIMEOUT,    32'd5);
    reg_write(rcfp_pkg::REG_HDR_FIRST,  32'hFF);
    reg_write(rcfp_pkg::REG_HDR_SECOND, 32'h00);
    queue_traffic(12, 1'b0);
    wait_quiet();

    // full rate, identical header bytes, one long result hold-off mid-stream
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(rcfp_pkg::REG_TIMEOUT,    32'd3);
    reg_write(rcfp_pkg::REG_HDR_FIRST,  32'h55);
    reg_write(rcfp_pkg::REG_HDR_SECOND, 32'h55);
    queue_traffic(16, 1'b0);
    repeat (5) @(negedge clk);
    holdoff_req = 1'b1;
    wait_quiet();

    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
